// ===== hdl/hedb_pkg.sv =====
// Package for the hex escape decoder: character codes, match states,
// the result burst type and the hex digit helpers. No dependencies.
package hedb_pkg;

  localparam int unsigned MaxBurst = 6;
  localparam int unsigned HeldMax  = 5;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Match progress; each state names the bytes currently held back
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_AMP  = 6'b000010,
    ST_HASH = 6'b000100,
    ST_X    = 6'b001000,
    ST_HI   = 6'b010000,
    ST_LO   = 6'b100000
  } stage_t;

  // Output words caused by one input word, first word in slot 0
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     last;
  } burst_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Folds case, then maps '0'..'9' and 'a'..'f' onto 0..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = (c | 8'h20) - 8'h30;
    if (v > 8'd9) v = v - 8'h27;
    return v[3:0];
  endfunction

  // Number of bytes held back in a given state
  function automatic logic [2:0] held_len(input stage_t s);
    logic [2:0] n;
    case (s)
      ST_AMP:  n = 3'd1;
      ST_HASH: n = 3'd2;
      ST_X:    n = 3'd3;
      ST_HI:   n = 3'd4;
      ST_LO:   n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/hedb_in_reg.sv =====
// Input register of the hex escape decoder: captures one word and holds it
// until the match logic consumes it. Depends on nothing.
module hedb_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       reg_valid,
  output logic [7:0] reg_byte,
  output logic       reg_last
);

  logic accept;

  // Room when empty or when the held word moves on this cycle
  assign in_stall = reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= 1'b0;
    end else if (accept) begin
      reg_valid <= 1'b1;
    end else if (advance) begin
      reg_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      reg_byte <= in_byte;
      reg_last <= in_last;
    end
  end

endmodule

// ===== hdl/hedb_match.sv =====
// Escape matcher: tracks the partial "&#xHL;" match and builds the burst of
// output words for the current input word. Depends on hedb_pkg.
module hedb_match (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      cur_byte,
  input  logic            cur_last,
  output hedb_pkg::burst_t burst
);

  hedb_pkg::stage_t stage, stage_next;
  logic [7:0] high_digit, high_digit_next;
  logic [7:0] low_digit, low_digit_next;

  logic       hit;
  logic [7:0] hi_upd, lo_upd;
  logic [2:0] plen;
  logic       ext_v;
  logic [7:0] ext_b;
  logic [hedb_pkg::HeldMax-1:0][7:0] held;

  // Does the current word continue the match
  always_comb begin
    case (stage)
      hedb_pkg::ST_AMP:  hit = (cur_byte == hedb_pkg::CH_HASH);
      hedb_pkg::ST_HASH: hit = (cur_byte == hedb_pkg::CH_X);
      hedb_pkg::ST_X:    hit = hedb_pkg::is_hex(cur_byte);
      hedb_pkg::ST_HI:   hit = hedb_pkg::is_hex(cur_byte);
      hedb_pkg::ST_LO:   hit = (cur_byte == hedb_pkg::CH_SEMI);
      default:           hit = 1'b0;
    endcase
  end

  // Next state, released prefix length and one extra word after it
  always_comb begin
    stage_next = stage;
    hi_upd     = high_digit;
    lo_upd     = low_digit;
    plen       = 3'd0;
    ext_v      = 1'b0;
    ext_b      = cur_byte;
    if (hit) begin
      case (stage)
        hedb_pkg::ST_AMP:  stage_next = hedb_pkg::ST_HASH;
        hedb_pkg::ST_HASH: stage_next = hedb_pkg::ST_X;
        hedb_pkg::ST_X: begin
          hi_upd     = cur_byte;
          stage_next = hedb_pkg::ST_HI;
        end
        hedb_pkg::ST_HI: begin
          lo_upd     = cur_byte;
          stage_next = hedb_pkg::ST_LO;
        end
        default: begin
          // full escape seen: emit the decoded byte
          ext_v      = 1'b1;
          ext_b      = {hedb_pkg::hex_val(high_digit), hedb_pkg::hex_val(low_digit)};
          stage_next = hedb_pkg::ST_IDLE;
        end
      endcase
      if (cur_last) plen = hedb_pkg::held_len(stage_next);
    end else begin
      // mismatch: release what is held, then look at this word afresh
      plen = hedb_pkg::held_len(stage);
      if (cur_byte == hedb_pkg::CH_AMP) begin
        stage_next = hedb_pkg::ST_AMP;
        ext_v      = cur_last;
        ext_b      = hedb_pkg::CH_AMP;
      end else begin
        stage_next = hedb_pkg::ST_IDLE;
        ext_v      = 1'b1;
      end
    end
    high_digit_next = hi_upd;
    low_digit_next  = lo_upd;
    if (cur_last) begin
      stage_next      = hedb_pkg::ST_IDLE;
      high_digit_next = 8'h00;
      low_digit_next  = 8'h00;
    end
  end

  // Burst: held prefix, then the extra word
  assign held = {lo_upd, hi_upd, hedb_pkg::CH_X, hedb_pkg::CH_HASH, hedb_pkg::CH_AMP};

  always_comb begin
    for (int i = 0; i < hedb_pkg::MaxBurst; i++) begin
      if (i < hedb_pkg::HeldMax && 3'(i) < plen) begin
        burst.bytes[i] = held[i];
      end else begin
        burst.bytes[i] = ext_b;
      end
    end
    burst.cnt  = plen + {2'b00, ext_v};
    burst.last = cur_last;
  end

  // Match state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= hedb_pkg::ST_IDLE;
      high_digit <= 8'h00;
      low_digit  <= 8'h00;
    end else if (advance) begin
      stage      <= stage_next;
      high_digit <= high_digit_next;
      low_digit  <= low_digit_next;
    end
  end

endmodule

// ===== hdl/hedb_burst.sv =====
// Result register of the hex escape decoder: holds one burst and hands it
// out one word per handshake. Depends on hedb_pkg.
module hedb_burst (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  hedb_pkg::burst_t burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [hedb_pkg::MaxBurst-1:0][7:0] bytes;
  logic [2:0] rem;
  logic       blast;
  logic       take;
  logic       load;

  assign take     = out_valid && !out_stall;
  assign free     = !out_valid || (take && rem == 3'd1);
  assign load     = advance && burst.cnt != 3'd0;
  assign out_byte = bytes[0];
  assign out_last = blast && rem == 3'd1;

  // Word count and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= 3'd0;
      blast     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      rem       <= burst.cnt;
      blast     <= burst.last;
    end else if (take) begin
      if (rem == 3'd1) out_valid <= 1'b0;
      rem <= rem - 3'd1;
    end
  end

  // Payload shifts toward slot 0 as words leave
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
    end else if (take) begin
      bytes <= {8'h00, bytes[hedb_pkg::MaxBurst-1:1]};
    end
  end

endmodule

// ===== hdl/hex_escape_to_byte_decoder_top.sv =====
// Top level of the hex escape decoder: input register, matcher and result
// register. Depends on hedb_pkg, hedb_in_reg, hedb_match and hedb_burst.
//
// Replaces each "&#xHL;" (H, L hex digits of either case) in a byte stream
// with the byte 16*H+L and passes all other bytes through in order; a word
// with in_last flushes any partial match, and its final output word carries
// out_last. A word's output is registered in the result register after the
// input register has held the word. Plain bytes and completed escapes flow
// at one word per cycle while out_stall is low. A word whose matching fails,
// or a last word with bytes held, yields up to six output words; the result
// register drains them one per cycle while out_stall is low, and the input
// register takes its next word as the final one leaves. Bytes of a partial
// match yield no output until the match completes or fails.
module hex_escape_to_byte_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic             reg_valid;
  logic [7:0]       reg_byte;
  logic             reg_last;
  logic             free;
  logic             advance;
  hedb_pkg::burst_t burst;

  // Held word moves on once the result register can take its burst
  assign advance = reg_valid && free;

  hedb_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .advance   (advance),
    .reg_valid (reg_valid),
    .reg_byte  (reg_byte),
    .reg_last  (reg_last)
  );

  hedb_match u_match (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cur_byte (reg_byte),
    .cur_last (reg_last),
    .burst    (burst)
  );

  hedb_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
